### src/svc_pkg.sv
package svc_pkg;

  // Function select on the input channel
  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  // Result kinds on the output channel
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_VALUE = 1'b1;

  // Byte codes of the format
  localparam logic [7:0] NEG_PREFIX = 8'hF1;
  localparam logic [7:0] TAG_TWO    = 8'h80;
  localparam logic [7:0] TAG_THREE  = 8'hC0;
  localparam logic [7:0] TAG_FOUR   = 8'hE0;
  localparam logic [7:0] TAG_RAW    = 8'hF0;

  // Magnitude limits for each code length
  localparam logic [31:0] LIM_ONE   = 32'h0000_007F;
  localparam logic [31:0] LIM_TWO   = 32'h0000_3FFF;
  localparam logic [31:0] LIM_THREE = 32'h001F_FFFF;
  localparam logic [31:0] LIM_FOUR  = 32'h0FFF_FFFF;

  // Lead byte payload masks
  localparam logic [7:0] MASK_TWO   = 8'h7F;
  localparam logic [7:0] MASK_THREE = 8'h3F;
  localparam logic [7:0] MASK_FOUR  = 8'h1F;

  localparam int SEQ_MAX = 6;
  localparam int SVC_FIFO_DEPTH = 4;

  // One queued job: either a byte sequence to send or one decoded value
  typedef struct packed {
    logic                      is_value;
    logic [2:0]                len;
    logic [SEQ_MAX-1:0][7:0]   seq;
    logic [31:0]               value;
  } svc_entry_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic empty;
    logic full;
  } svc_q_stat_t;

endpackage

### src/svc_ifs.sv
interface svc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] value_in;
  logic [7:0]  byte_in;

  modport source (output valid, output func, output value_in, output byte_in, input ready);
  modport sink   (input valid, input func, input value_in, input byte_in, output ready);
endinterface

interface svc_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  byte_out;
  logic [31:0] value_out;
  logic        last;

  modport source (output valid, output kind, output byte_out, output value_out, output last,
                  input ready);
  modport sink   (input valid, input kind, input byte_out, input value_out, input last,
                  output ready);
endinterface

### src/signed_varint_codec.sv
// Channel  Dir  Beat carries
// in_ch    in   func, value_in (encode), byte_in (decode)
// out_ch   out  kind, byte_out, value_out, last
//
// Decode takes one stream byte per cycle; a finished value passes the queue and the
// output register after its closing byte. Encode takes one value per cycle into the
// queue; out_ch moves one byte per cycle unless stalled, so a value is 1 to 6 beats.
// Reset (rst_n, synchronous) clears the decode state, the queue and the output valid.
// A stalled out_ch holds its beat; in_ch stalls only when the queue is full.
module signed_varint_codec #(
  parameter int FIFO_DEPTH = svc_pkg::SVC_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  svc_in_if.sink     in_ch,
  svc_out_if.source  out_ch
);
  import svc_pkg::*;

  svc_entry_t  push_entry, head;
  svc_q_stat_t q_stat;
  logic        push, pop;

  // Front: accept beats, run the decode state, build encode sequences
  svc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  // Queue between front and back
  svc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  // Back: serialize beats into the output register, one per cycle unless out_ch stalls
  svc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

### src/svc_front.sv
module svc_front (
  input  logic                clk,
  input  logic                rst_n,
  svc_in_if.sink              in_ch,
  input  svc_pkg::svc_q_stat_t q_stat,
  output logic                push,
  output svc_pkg::svc_entry_t push_entry
);
  import svc_pkg::*;

  logic [2:0]  bytes_left_r, bytes_left_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        neg_r, neg_nxt;

  logic        accept;
  logic [31:0] mag;
  logic        is_neg;
  logic [4:0][7:0] code;
  logic [2:0]  code_len;
  logic        done;
  logic [7:0]  b;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.byte_in;

  // Encode: build the byte code of one value's magnitude
  always_comb begin
    is_neg = in_ch.value_in[31];
    mag    = is_neg ? (32'd0 - in_ch.value_in) : in_ch.value_in;
    code   = '0;
    if (mag < LIM_ONE) begin
      code[0]  = mag[7:0];
      code_len = 3'd1;
    end else if (mag < LIM_TWO) begin
      code[0]  = TAG_TWO | mag[15:8];
      code[1]  = mag[7:0];
      code_len = 3'd2;
    end else if (mag < LIM_THREE) begin
      code[0]  = TAG_THREE | mag[23:16];
      code[1]  = mag[15:8];
      code[2]  = mag[7:0];
      code_len = 3'd3;
    end else if (mag < LIM_FOUR) begin
      code[0]  = TAG_FOUR | mag[31:24];
      code[1]  = mag[23:16];
      code[2]  = mag[15:8];
      code[3]  = mag[7:0];
      code_len = 3'd4;
    end else begin
      code[0]  = TAG_RAW;
      code[1]  = mag[31:24];
      code[2]  = mag[23:16];
      code[3]  = mag[15:8];
      code[4]  = mag[7:0];
      code_len = 3'd5;
    end
  end

  // Decode: advance the stream state by one byte
  always_comb begin
    bytes_left_nxt = bytes_left_r;
    acc_nxt        = acc_r;
    neg_nxt        = neg_r;
    done           = 1'b0;
    if (accept && in_ch.func == FUNC_DECODE) begin
      if (bytes_left_r != 3'd0) begin
        acc_nxt        = {acc_r[23:0], b};
        bytes_left_nxt = bytes_left_r - 3'd1;
        done           = (bytes_left_r == 3'd1);
      end else if (b == NEG_PREFIX) begin
        neg_nxt = !neg_r;
      end else if (!b[7]) begin
        acc_nxt = {24'd0, b};
        done    = 1'b1;
      end else begin
        case (b[7:4])
          4'h8, 4'h9, 4'hA, 4'hB: begin
            acc_nxt        = {24'd0, b & MASK_TWO};
            bytes_left_nxt = 3'd1;
          end
          4'hC, 4'hD: begin
            acc_nxt        = {24'd0, b & MASK_THREE};
            bytes_left_nxt = 3'd2;
          end
          4'hE: begin
            acc_nxt        = {24'd0, b & MASK_FOUR};
            bytes_left_nxt = 3'd3;
          end
          default: begin
            acc_nxt        = 32'd0;
            bytes_left_nxt = 3'd4;
          end
        endcase
      end
      if (done) begin
        neg_nxt        = 1'b0;
        bytes_left_nxt = 3'd0;
      end
    end
  end

  // Queue entry
  always_comb begin
    push_entry       = '0;
    push_entry.value = neg_r ? (32'd0 - acc_nxt) : acc_nxt;
    if (in_ch.func == FUNC_ENCODE) begin
      push_entry.is_value = 1'b0;
      if (is_neg) begin
        push_entry.seq[0] = NEG_PREFIX;
        for (int k = 0; k < 5; k++) begin
          push_entry.seq[k+1] = code[k];
        end
        push_entry.len = code_len + 3'd1;
      end else begin
        for (int k = 0; k < 5; k++) begin
          push_entry.seq[k] = code[k];
        end
        push_entry.len = code_len;
      end
    end else begin
      push_entry.is_value = 1'b1;
      push_entry.len      = 3'd1;
    end
  end

  assign push = accept && (in_ch.func == FUNC_ENCODE || done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= 3'd0;
      acc_r        <= 32'd0;
      neg_r        <= 1'b0;
    end else begin
      bytes_left_r <= bytes_left_nxt;
      acc_r        <= acc_nxt;
      neg_r        <= neg_nxt;
    end
  end

endmodule

### src/svc_fifo.sv
module svc_fifo #(
  parameter int DEPTH = svc_pkg::SVC_FIFO_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  svc_pkg::svc_entry_t  push_entry,
  input  logic                 pop,
  output svc_pkg::svc_entry_t  head,
  output svc_pkg::svc_q_stat_t q_stat
);
  import svc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  svc_entry_t      mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push, do_pop;

  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == FULL_CNT);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

### src/svc_back.sv
module svc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  svc_pkg::svc_entry_t  head,
  input  svc_pkg::svc_q_stat_t q_stat,
  output logic                 pop,
  svc_out_if.source            out_ch
);
  import svc_pkg::*;

  logic [2:0]  idx_r;
  logic        valid_r;
  logic        kind_r;
  logic [7:0]  byte_r;
  logic [31:0] value_r;
  logic        last_r;
  logic        load, take, at_end;

  assign load   = !valid_r || out_ch.ready;
  assign take   = load && !q_stat.empty;
  assign at_end = head.is_value || (idx_r == head.len - 3'd1);
  assign pop    = take && at_end;

  assign out_ch.valid     = valid_r;
  assign out_ch.kind      = kind_r;
  assign out_ch.byte_out  = byte_r;
  assign out_ch.value_out = value_r;
  assign out_ch.last      = last_r;

  always_ff @(posedge clk) begin
    if (take) begin
      if (head.is_value) begin
        kind_r  <= KIND_VALUE;
        byte_r  <= 8'd0;
        value_r <= head.value;
        last_r  <= 1'b1;
      end else begin
        kind_r  <= KIND_BYTE;
        byte_r  <= head.seq[idx_r];
        value_r <= 32'd0;
        last_r  <= at_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 3'd0;
    end else begin
      if (load) begin
        valid_r <= !q_stat.empty;
      end
      if (take) begin
        idx_r <= at_end ? 3'd0 : idx_r + 3'd1;
      end
    end
  end

endmodule
